// ===== src/gtg_pkg.sv =====
package gtg_pkg;

    // Width of the CORDIC x and y datapath. Inputs are pre-scaled so that the
    // coordinate width plus the pre-scale shift is always PRESCALE_BASE bits.
    localparam int DATA_W        = 62;
    localparam int PRESCALE_BASE = 58;
    localparam int ANG_W         = 16;
    localparam int TURN_W        = 15;
    localparam int MOVE_W        = 16;
    localparam int APB_W         = 32;

    // Register map, indexed by paddr[2].
    localparam logic REG_MOVE = 1'b0;
    localparam logic REG_TURN = 1'b1;

    localparam logic [MOVE_W-1:0] MOVE_RESET = 16'd102;
    localparam logic [TURN_W-1:0] TURN_RESET = 15'd2086;

    typedef enum logic [1:0] {
        ACT_STAY    = 2'd0,
        ACT_FORWARD = 2'd1,
        ACT_LEFT    = 2'd2,
        ACT_RIGHT   = 2'd3
    } t_action;

    // One beat as it moves through the CORDIC stages.
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [ANG_W-1:0]         z;
        logic [ANG_W-1:0]         heading;
        logic                     zero;
        logic                     near;
    } t_cordic;

    // Rounded atan(2^-i) in binary-angle units; later iterations add nothing.
    function automatic logic [ANG_W-1:0] atan_entry(input int unsigned idx);
        case (idx)
            0:       return 16'd8192;
            1:       return 16'd4836;
            2:       return 16'd2555;
            3:       return 16'd1297;
            4:       return 16'd651;
            5:       return 16'd326;
            6:       return 16'd163;
            7:       return 16'd81;
            8:       return 16'd41;
            9:       return 16'd20;
            10:      return 16'd10;
            11:      return 16'd5;
            12:      return 16'd3;
            13:      return 16'd1;
            14:      return 16'd1;
            default: return 16'd0;
        endcase
    endfunction

endpackage

// ===== src/go_to_goal_action_select.sv =====
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_pose_x, i_pose_y, i_heading, i_goal_x, i_goal_y
// output    out        o_valid / i_stall   o_action, o_relative_angle
// config    in         psel/penable/pready paddr, pwdata, prdata (APB, two registers)
//
// One beat is accepted per cycle while o_stall is low. Each beat passes through the
// pipeline: one offset stage, one fold and square stage, one register per CORDIC
// iteration, and the output register. The CORDIC iteration count sets the depth.
// Reset is synchronous; it clears all valid bits and loads both thresholds with
// their reset values.
// Each stage moves whenever the stage after it is empty or moving, so bubbles close
// up under a stall and input is held off only when every stage is full.
module go_to_goal_action_select import gtg_pkg::*; #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pose_x,
    input  logic signed [COORD_WIDTH-1:0] i_pose_y,
    input  logic signed [ANG_W-1:0]       i_heading,
    input  logic signed [COORD_WIDTH-1:0] i_goal_x,
    input  logic signed [COORD_WIDTH-1:0] i_goal_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_action,
    output logic signed [ANG_W-1:0]       o_relative_angle,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [APB_W-1:0]              pwdata,
    output logic [APB_W-1:0]              prdata,
    output logic                          pready
);

    localparam int NUM_REGS = CORDIC_STAGES + 3;

    logic [NUM_REGS-1:0] w_valid;
    logic [NUM_REGS-1:0] w_adv;
    t_cordic             w_stage [0:CORDIC_STAGES];
    logic [2*MOVE_W-1:0] w_move_sq;
    logic [TURN_W-1:0]   w_turn_threshold;

    // Advance chain: a stage moves if it is empty or its successor moves.
    assign w_adv[NUM_REGS-1] = !w_valid[NUM_REGS-1] || !i_stall;

    for (genvar k = 0; k < NUM_REGS - 1; k++) begin : g_adv
        assign w_adv[k] = !w_valid[k] || w_adv[k+1];
    end

    assign o_stall = !w_adv[0];
    assign o_valid = w_valid[NUM_REGS-1];

    gtg_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_move_sq        (w_move_sq),
        .o_turn_threshold (w_turn_threshold)
    );

    gtg_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_adv_a   (w_adv[0]),
        .i_adv_b   (w_adv[1]),
        .i_pose_x  (i_pose_x),
        .i_pose_y  (i_pose_y),
        .i_heading (i_heading),
        .i_goal_x  (i_goal_x),
        .i_goal_y  (i_goal_y),
        .i_move_sq (w_move_sq),
        .o_valid_a (w_valid[0]),
        .o_valid_b (w_valid[1]),
        .o_stage   (w_stage[0])
    );

    // One registered CORDIC iteration per stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        gtg_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[i+1]),
            .i_adv   (w_adv[i+2]),
            .i_stage (w_stage[i]),
            .o_valid (w_valid[i+2]),
            .o_stage (w_stage[i+1])
        );
    end

    gtg_decide u_decide (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_valid[NUM_REGS-2]),
        .i_adv            (w_adv[NUM_REGS-1]),
        .i_stage          (w_stage[CORDIC_STAGES]),
        .i_turn_threshold (w_turn_threshold),
        .o_valid          (w_valid[NUM_REGS-1]),
        .o_action         (o_action),
        .o_relative_angle (o_relative_angle)
    );

endmodule

// ===== src/gtg_cfg.sv =====
module gtg_cfg import gtg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready,
    output logic [2*MOVE_W-1:0] o_move_sq,
    output logic [TURN_W-1:0]   o_turn_threshold
);

    logic [MOVE_W-1:0]   r_move_threshold;
    logic [TURN_W-1:0]   r_turn_threshold;
    logic [2*MOVE_W-1:0] r_move_sq;
    logic                w_write;
    logic                w_index;

    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[2];
    assign pready  = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_threshold <= MOVE_RESET;
            r_turn_threshold <= TURN_RESET;
        end else if (w_write) begin
            case (w_index)
                REG_MOVE: r_move_threshold <= pwdata[MOVE_W-1:0];
                REG_TURN: r_turn_threshold <= pwdata[TURN_W-1:0];
                default: ;
            endcase
        end
    end

    // The squared move threshold is kept registered for the distance compare.
    always_ff @(posedge i_clk) begin
        r_move_sq <= r_move_threshold * r_move_threshold;
    end

    always_comb begin
        case (w_index)
            REG_MOVE: prdata = {{(APB_W-MOVE_W){1'b0}}, r_move_threshold};
            REG_TURN: prdata = {{(APB_W-TURN_W){1'b0}}, r_turn_threshold};
            default:  prdata = '0;
        endcase
    end

    assign o_move_sq        = r_move_sq;
    assign o_turn_threshold = r_turn_threshold;

endmodule

// ===== src/gtg_prep.sv =====
module gtg_prep import gtg_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_adv_a,
    input  logic                          i_adv_b,
    input  logic signed [COORD_WIDTH-1:0] i_pose_x,
    input  logic signed [COORD_WIDTH-1:0] i_pose_y,
    input  logic signed [ANG_W-1:0]       i_heading,
    input  logic signed [COORD_WIDTH-1:0] i_goal_x,
    input  logic signed [COORD_WIDTH-1:0] i_goal_y,
    input  logic [2*MOVE_W-1:0]           i_move_sq,
    output logic                          o_valid_a,
    output logic                          o_valid_b,
    output t_cordic                       o_stage
);

    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int SQ_W     = 2 * COORD_WIDTH;
    localparam int SUM_W    = SQ_W + 1;
    localparam int CMP_W    = (SUM_W > 2 * MOVE_W) ? SUM_W : 2 * MOVE_W;
    localparam int PRESCALE = PRESCALE_BASE - COORD_WIDTH;

    // First stage: target offset.
    logic                     r_valid_a;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [ANG_W-1:0]         r_heading_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else if (i_adv_a) begin
            r_valid_a <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv_a) begin
            r_dx        <= DIFF_W'(i_goal_x) - DIFF_W'(i_pose_x);
            r_dy        <= DIFF_W'(i_goal_y) - DIFF_W'(i_pose_y);
            r_heading_a <= i_heading;
        end
    end

    // Second stage: fold the vector into the right half-plane, pre-scale it,
    // and square the offsets for the distance test.
    logic                     w_neg;
    logic signed [DIFF_W-1:0] w_mdx;
    logic signed [DIFF_W-1:0] w_mdy;
    logic [DIFF_W-1:0]        w_adx;
    logic [DIFF_W-1:0]        w_ady;
    logic [SQ_W-1:0]          n_sqx;
    logic [SQ_W-1:0]          n_sqy;

    always_comb begin
        w_neg = r_dx[DIFF_W-1];
        w_mdx = w_neg ? -r_dx : r_dx;
        w_mdy = w_neg ? -r_dy : r_dy;
        w_adx = r_dx[DIFF_W-1] ? -r_dx : r_dx;
        w_ady = r_dy[DIFF_W-1] ? -r_dy : r_dy;
        n_sqx = w_adx[COORD_WIDTH-1:0] * w_adx[COORD_WIDTH-1:0];
        n_sqy = w_ady[COORD_WIDTH-1:0] * w_ady[COORD_WIDTH-1:0];
    end

    logic                     r_valid_b;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic [ANG_W-1:0]         r_z;
    logic [ANG_W-1:0]         r_heading_b;
    logic                     r_zero;
    logic [SQ_W-1:0]          r_sqx;
    logic [SQ_W-1:0]          r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
        end else if (i_adv_b) begin
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv_b) begin
            r_x         <= DATA_W'(w_mdx) <<< PRESCALE;
            r_y         <= DATA_W'(w_mdy) <<< PRESCALE;
            r_z         <= w_neg ? {1'b1, {(ANG_W-1){1'b0}}} : '0;
            r_heading_b <= r_heading_a;
            r_zero      <= (r_dx == '0) && (r_dy == '0);
            r_sqx       <= n_sqx;
            r_sqy       <= n_sqy;
        end
    end

    // The distance compare rides along with the first CORDIC iteration.
    logic [SUM_W-1:0] w_sum;

    always_comb begin
        w_sum           = SUM_W'(r_sqx) + SUM_W'(r_sqy);
        o_stage.x       = r_x;
        o_stage.y       = r_y;
        o_stage.z       = r_z;
        o_stage.heading = r_heading_b;
        o_stage.zero    = r_zero;
        o_stage.near    = CMP_W'(w_sum) < CMP_W'(i_move_sq);
    end

    assign o_valid_a = r_valid_a;
    assign o_valid_b = r_valid_b;

endmodule

// ===== src/gtg_cordic_stage.sv =====
module gtg_cordic_stage import gtg_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_adv,
    input  t_cordic i_stage,
    output logic    o_valid,
    output t_cordic o_stage
);

    logic                     r_valid;
    t_cordic                  r_stage;
    t_cordic                  n_stage;
    logic signed [DATA_W-1:0] w_xs;
    logic signed [DATA_W-1:0] w_ys;
    logic                     w_pos;

    // One vectoring iteration: rotate toward the x axis and track the angle.
    always_comb begin
        w_xs    = $signed(i_stage.x) >>> STAGE;
        w_ys    = $signed(i_stage.y) >>> STAGE;
        w_pos   = !i_stage.y[DATA_W-1];
        n_stage = i_stage;
        if (w_pos) begin
            n_stage.x = i_stage.x + w_ys;
            n_stage.y = i_stage.y - w_xs;
            n_stage.z = i_stage.z + atan_entry(STAGE);
        end else begin
            n_stage.x = i_stage.x - w_ys;
            n_stage.y = i_stage.y + w_xs;
            n_stage.z = i_stage.z - atan_entry(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== src/gtg_decide.sv =====
module gtg_decide import gtg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_adv,
    input  t_cordic                 i_stage,
    input  logic [TURN_W-1:0]       i_turn_threshold,
    output logic                    o_valid,
    output logic [1:0]              o_action,
    output logic signed [ANG_W-1:0] o_relative_angle
);

    logic [ANG_W-1:0] w_bearing;
    logic [ANG_W-1:0] w_rel;
    logic [ANG_W-1:0] w_mag;
    logic             w_left;
    t_action          n_action;

    // Local angle wraps for free in 16 bits. The code for -pi counts as +pi:
    // its magnitude is 32768 and it turns left.
    always_comb begin
        w_bearing = i_stage.zero ? '0 : i_stage.z;
        w_rel     = w_bearing - i_stage.heading;
        w_mag     = w_rel[ANG_W-1] ? -w_rel : w_rel;
        w_left    = (!w_rel[ANG_W-1] && (w_rel != '0))
                    || (w_rel == {1'b1, {(ANG_W-1){1'b0}}});
        if (i_stage.near) begin
            n_action = ACT_STAY;
        end else if (w_mag < {1'b0, i_turn_threshold}) begin
            n_action = ACT_FORWARD;
        end else if (w_left) begin
            n_action = ACT_LEFT;
        end else begin
            n_action = ACT_RIGHT;
        end
    end

    // Output register; it holds its beat while the consumer stalls.
    logic             r_valid;
    t_action          r_action;
    logic [ANG_W-1:0] r_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_action <= n_action;
            r_rel    <= w_rel;
        end
    end

    assign o_valid          = r_valid;
    assign o_action         = r_action;
    assign o_relative_angle = r_rel;

endmodule

// ===== src/gtg_checker.sv =====
module gtg_checker import gtg_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [1:0]              o_action,
    input logic signed [ANG_W-1:0] o_relative_angle
);

    // A held result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_action) && $stable(o_relative_angle))
        else $error("output beat changed while stalled");

    // With the output register empty the whole pipeline can move.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output register is empty");

    // The -pi code counts as +pi: never forward or right.
    a_minus_pi_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_relative_angle == 16'sh8000)
        |-> (o_action == ACT_STAY) || (o_action == ACT_LEFT))
        else $error("angle of pi gave a wrong action");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind go_to_goal_action_select gtg_checker u_gtg_checker (.*);
